>>> hdl/lol_pkg.sv
// package with shared types and codes for the lru order list
`timescale 1ns / 1ps

package lol_pkg;

  localparam int DEF_ENTRIES = 256;
  localparam int IDX_W = 8;
  localparam int LEN_W = 9;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_QUEUED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_QUEUED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UNLINK,
    S_LINK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic set_status;
    logic [STAT_W-1:0] status_code;
    logic do_link;
    logic do_unlink;
    logic do_clear;
    logic load_out;
  } lol_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic idx_valid;
    logic queued;
    logic len_zero;
    logic is_tail;
  } lol_sts_t;

endpackage

>>> hdl/lol_ctrl.sv
// controller state machine sequencing list operations
`timescale 1ns / 1ps

module lol_ctrl import lol_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  lol_sts_t sts,
  output lol_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (sts.kind)
          KIND_POP: begin
            if (!sts.len_zero) state_next = S_UNLINK;
          end
          KIND_REMOVE: begin
            if (sts.queued) state_next = S_UNLINK;
          end
          KIND_MOVE: begin
            if (sts.queued && !sts.is_tail) state_next = S_UNLINK;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_UNLINK: begin
        state_next = (sts.kind == KIND_MOVE) ? S_LINK : S_DONE;
      end
      S_LINK: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.capture = in_valid && in_ready;
      S_DECODE: begin
        cmd.set_status = 1'b1;
        cmd.status_code = STAT_OK;
        case (sts.kind)
          KIND_PUSH: begin
            if (!sts.idx_valid) begin
              cmd.status_code = STAT_NOT_QUEUED;
            end else if (sts.queued) begin
              cmd.status_code = STAT_QUEUED;
            end else begin
              cmd.do_link = 1'b1;
            end
          end
          KIND_POP: begin
            if (sts.len_zero) cmd.status_code = STAT_EMPTY;
          end
          KIND_REMOVE, KIND_MOVE: begin
            if (!sts.queued) cmd.status_code = STAT_NOT_QUEUED;
          end
          KIND_CLEAR: cmd.do_clear = 1'b1;
          default: cmd.status_code = STAT_OK;
        endcase
      end
      S_UNLINK: cmd.do_unlink = 1'b1;
      S_LINK: cmd.do_link = 1'b1;
      S_DONE: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/lol_datapath.sv
// datapath with link memories, membership bits, head, tail and length
`timescale 1ns / 1ps

module lol_datapath import lol_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [IDX_W-1:0]  in_idx,
  input  lol_cmd_t          cmd,
  output lol_sts_t          sts,
  output logic [STAT_W-1:0] out_status,
  output logic [IDX_W-1:0]  out_popped_index,
  output logic              out_popped_valid,
  output logic [LEN_W-1:0]  out_queue_length
);

  localparam int SLOTS = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);
  localparam int AW = $clog2(SLOTS);

  logic [IDX_W-1:0] next_mem [SLOTS];
  logic [IDX_W-1:0] prev_mem [SLOTS];
  logic [SLOTS-1:0] in_list;

  logic [KIND_W-1:0] cur_kind;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [LEN_W-1:0] length;
  logic [IDX_W-1:0] rd_next;
  logic [IDX_W-1:0] rd_prev;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0] res_popped;
  logic res_pvalid;

  logic [IDX_W-1:0] op_slot;
  logic is_pop;
  logic un_head;
  logic un_tail;

  logic nx_we;
  logic [AW-1:0] nx_addr;
  logic [IDX_W-1:0] nx_data;
  logic pv_we;
  logic [AW-1:0] pv_addr;
  logic [IDX_W-1:0] pv_data;

  assign is_pop = (cur_kind == KIND_POP);
  assign op_slot = is_pop ? head : cur_idx;
  assign un_head = (op_slot == head);
  assign un_tail = (op_slot == tail);

  assign sts.kind = cur_kind;
  assign sts.idx_valid = (32'(cur_idx) < ENTRIES);
  assign sts.queued = sts.idx_valid && in_list[AW'(cur_idx)];
  assign sts.len_zero = (length == '0);
  assign sts.is_tail = (cur_idx == tail);

  // link memory write ports
  always_comb begin
    nx_we = 1'b0;
    nx_addr = AW'(tail);
    nx_data = cur_idx;
    pv_we = 1'b0;
    pv_addr = AW'(cur_idx);
    pv_data = tail;
    if (cmd.do_link) begin
      nx_we = (length != '0);
      pv_we = (length != '0);
    end else if (cmd.do_unlink && !un_head && !un_tail) begin
      nx_we = 1'b1;
      nx_addr = AW'(rd_prev);
      nx_data = rd_next;
      pv_we = 1'b1;
      pv_addr = AW'(rd_next);
      pv_data = rd_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_addr] <= nx_data;
    if (pv_we) prev_mem[pv_addr] <= pv_data;
    rd_next <= next_mem[AW'(op_slot)];
    rd_prev <= prev_mem[AW'(op_slot)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_list <= '0;
      head <= '0;
      tail <= '0;
      length <= '0;
    end else if (cmd.do_clear) begin
      in_list <= '0;
      head <= '0;
      tail <= '0;
      length <= '0;
    end else if (cmd.do_link) begin
      if (length == '0) head <= cur_idx;
      tail <= cur_idx;
      in_list[AW'(cur_idx)] <= 1'b1;
      length <= length + 1'b1;
    end else if (cmd.do_unlink) begin
      if (un_head && un_tail) begin
        head <= '0;
        tail <= '0;
      end else if (un_head) begin
        head <= rd_next;
      end else if (un_tail) begin
        tail <= rd_prev;
      end
      in_list[AW'(op_slot)] <= 1'b0;
      length <= length - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_kind <= in_kind;
      cur_idx <= in_idx;
      res_popped <= '0;
      res_pvalid <= 1'b0;
    end else if (cmd.do_unlink && is_pop) begin
      res_popped <= head;
      res_pvalid <= 1'b1;
    end
    if (cmd.set_status) res_status <= cmd.status_code;
    if (cmd.load_out) begin
      out_status <= res_status;
      out_popped_index <= res_popped;
      out_popped_valid <= res_pvalid;
      out_queue_length <= length;
    end
  end

endmodule

>>> hdl/lru_order_list_top.sv
// top level of the lru order list
`timescale 1ns / 1ps
// Keeps a recency order over slots as a doubly linked list in two link
// memories. Each input word on the s_axis channel is one operation
// (push, pop, remove, move to end, clear) on the slot in tdata; each
// gives exactly one result word on the m_axis channel with a status,
// the popped slot and its valid flag, and the list length afterwards.
// One operation is in flight at a time. After acceptance each passes a
// decode step; pop and remove then take an unlink step, and move to end
// of a queued slot that is not the tail an unlink and a relink step, the
// link memories being read through a register. Push, clear and the other
// cases go straight from decode to the result. A new word is not taken
// until the previous operation is through.
// The result sits in an output register: the next word is accepted
// once the previous result is loaded there, even if it is not taken.
// When the receiver stalls, the following operation waits in its last
// step until the output register is free, and s_axis_tready stays low.
// Reset empties the list at once and holds s_axis_tready low.

module lru_order_list_top import lol_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // entry_index
  input  logic [2:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // popped_index, queue_length, zero fill
  output logic [2:0]  m_axis_tuser    // status, popped_valid
);

  lol_cmd_t cmd;
  lol_sts_t sts;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0] out_popped_index;
  logic out_popped_valid;
  logic [LEN_W-1:0] out_queue_length;

  lol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  lol_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .in_kind          (s_axis_tuser),
    .in_idx           (s_axis_tdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_popped_index (out_popped_index),
    .out_popped_valid (out_popped_valid),
    .out_queue_length (out_queue_length)
  );

  assign m_axis_tdata = {7'd0, out_queue_length, out_popped_index};
  assign m_axis_tuser = {out_popped_valid, out_status};

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench for lru_order_list_top with a behavioral recency-list predictor and random traffic

module testbench;
  import lol_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES = 24;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0] slot;
    bit hold;
    int phase;
  } list_op_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0] popped;
    logic popped_valid;
    logic [LEN_W-1:0] length;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  list_op_t op_queue[$];
  list_result_t awaited_results[$];
  int failures = 0;
  int cycle_count = 0;
  int recv_idle_pct = 0;

  // shadow of the linked list
  logic [IDX_W-1:0] link_next[DEF_ENTRIES];
  logic [IDX_W-1:0] link_prev[DEF_ENTRIES];
  bit slot_queued[DEF_ENTRIES];
  logic [IDX_W-1:0] order_head = '0;
  logic [IDX_W-1:0] order_tail = '0;
  logic [LEN_W-1:0] order_len = '0;

  list_op_t next_op;
  list_result_t got;
  list_result_t want;
  logic send_now;
  int send_idle_pct;

  lru_order_list_top DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #6 clk = ~clk;

  function automatic void append_slot(logic [IDX_W-1:0] s);
    if (order_len == 0) begin
      order_head = s;
    end else begin
      link_next[order_tail] = s;
      link_prev[s] = order_tail;
    end
    order_tail = s;
    slot_queued[s] = 1'b1;
    order_len++;
  endfunction

  function automatic void unlink_slot(logic [IDX_W-1:0] s);
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    p = link_prev[s];
    n = link_next[s];
    if (s == order_head && s == order_tail) begin
      order_head = '0;
      order_tail = '0;
    end else if (s == order_head) begin
      order_head = n;
    end else if (s == order_tail) begin
      order_tail = p;
    end else begin
      link_next[p] = n;
      link_prev[n] = p;
    end
    slot_queued[s] = 1'b0;
    order_len--;
  endfunction

  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind,
                                                 logic [IDX_W-1:0] slot);
    list_result_t r;
    r.status = STAT_OK;
    r.popped = '0;
    r.popped_valid = 1'b0;
    case (kind)
      KIND_PUSH: begin
        if (slot_queued[slot]) r.status = STAT_QUEUED;
        else append_slot(slot);
      end
      KIND_POP: begin
        if (order_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = order_head;
          r.popped_valid = 1'b1;
          unlink_slot(order_head);
        end
      end
      KIND_REMOVE: begin
        if (!slot_queued[slot]) r.status = STAT_NOT_QUEUED;
        else unlink_slot(slot);
      end
      KIND_MOVE: begin
        if (!slot_queued[slot]) begin
          r.status = STAT_NOT_QUEUED;
        end else if (slot != order_tail) begin
          unlink_slot(slot);
          append_slot(slot);
        end
      end
      KIND_CLEAR: begin
        foreach (slot_queued[i]) slot_queued[i] = 1'b0;
        order_head = '0;
        order_tail = '0;
        order_len = '0;
      end
      default: ;
    endcase
    r.length = order_len;
    return r;
  endfunction

  task automatic add_op(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] slot, int phase,
                        bit hold = 1'b0);
    list_op_t op;
    op.kind = kind;
    op.slot = slot;
    op.phase = phase;
    op.hold = hold;
    op_queue.insert(op_queue.size(), op);
  endtask

  // mostly slots near base so that remove and move often hit queued entries
  task automatic add_random_op(logic [IDX_W-1:0] base, int spread, int phase);
    int r;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0] slot;
    r = $urandom_range(0, 99);
    if (r < 35) kind = KIND_PUSH;
    else if (r < 50) kind = KIND_POP;
    else if (r < 65) kind = KIND_REMOVE;
    else if (r < 87) kind = KIND_MOVE;
    else if (r < 90) kind = KIND_CLEAR;
    else if (r < 93) kind = KIND_W'($urandom_range(5, 7));
    else kind = KIND_PUSH;
    if ($urandom_range(0, 99) < 80) slot = base + IDX_W'($urandom_range(0, spread));
    else slot = IDX_W'($urandom_range(0, 255));
    add_op(kind, slot, phase);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.insert(awaited_results.size(),
                               apply_list_op(s_axis_tuser, s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        send_now = 1'b0;
        if (op_queue.size() > 0 && op_queue[0].hold && awaited_results.size() == 0)
          op_queue.delete(0);
        if (op_queue.size() > 0 && !op_queue[0].hold) begin
          case (op_queue[0].phase)
            0: begin
              send_idle_pct = 32;
              recv_idle_pct <= 68;
            end
            1: begin
              send_idle_pct = 68;
              recv_idle_pct <= 32;
            end
            default: begin
              send_idle_pct = 0;
              recv_idle_pct <= 0;
            end
          endcase
          if ($urandom_range(0, 99) >= send_idle_pct) begin
            next_op = op_queue[0];
            op_queue.delete(0);
            s_axis_tdata <= next_op.slot;
            s_axis_tuser <= next_op.kind;
            send_now = 1'b1;
          end
        end
        s_axis_tvalid <= send_now;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser[1:0];
      got.popped_valid = m_axis_tuser[2];
      got.popped = m_axis_tdata[7:0];
      got.length = m_axis_tdata[16:8];
      if (awaited_results.size() == 0) begin
        $error("result word with no operation outstanding");
        failures++;
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          failures++;
        end
        if (got.popped !== want.popped) begin
          $error("popped_index: expected %0d, actual %0d", want.popped, got.popped);
          failures++;
        end
        if (got.popped_valid !== want.popped_valid) begin
          $error("popped_valid: expected %0d, actual %0d", want.popped_valid,
                 got.popped_valid);
          failures++;
        end
        if (got.length !== want.length) begin
          $error("queue_length: expected %0d, actual %0d", want.length, got.length);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("lru_order_list_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] step;
    // empty list corner cases
    add_op(KIND_POP, 8'd0, 0);
    add_op(KIND_REMOVE, 8'd5, 0);
    add_op(KIND_MOVE, 8'd5, 0);
    // build 0, 255, 128 and reject a duplicate push
    add_op(KIND_PUSH, 8'd0, 0);
    add_op(KIND_PUSH, 8'd255, 0);
    add_op(KIND_PUSH, 8'd0, 0);
    add_op(KIND_PUSH, 8'd128, 0);
    add_op(KIND_MOVE, 8'd128, 0);
    add_op(KIND_MOVE, 8'd0, 0);
    add_op(KIND_PUSH, 8'd7, 0);
    add_op(KIND_MOVE, 8'd128, 0);
    add_op(KIND_REMOVE, 8'd0, 0);
    add_op(KIND_REMOVE, 8'd255, 0);
    add_op(KIND_REMOVE, 8'd128, 0);
    add_op(3'd5, 8'd170, 0);
    add_op(3'd6, 8'd85, 0);
    add_op(3'd7, 8'd0, 0);
    add_op(KIND_REMOVE, 8'd7, 0);
    add_op(KIND_PUSH, 8'd3, 0);
    add_op(KIND_PUSH, 8'd9, 0);
    add_op(KIND_POP, 8'd0, 0);
    add_op(KIND_CLEAR, 8'd0, 0);
    add_op(KIND_PUSH, 8'd9, 0);
    add_op(KIND_POP, 8'd0, 0);
    add_op(KIND_POP, 8'd0, 0);
    add_op(KIND_PUSH, 8'd0, 0, 1'b1);

    base = IDX_W'($urandom_range(0, 255));
    repeat (115) add_random_op(base, 23, 0);
    add_op(KIND_PUSH, 8'd0, 1, 1'b1);
    base = IDX_W'($urandom_range(0, 255));
    repeat (115) add_random_op(base, 23, 1);
    add_op(KIND_PUSH, 8'd0, 2, 1'b1);

    // fill every slot in a scrambled order, then churn the full list
    base = IDX_W'($urandom_range(0, 255));
    step = {7'($urandom_range(0, 127)), 1'b1};
    for (int i = 0; i < DEF_ENTRIES; i++) add_op(KIND_PUSH, base + IDX_W'(i) * step, 2);
    repeat (40) add_random_op(base, 255, 2);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (op_queue.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) $display("lru_order_list_top: match");
    else $display("lru_order_list_top: mismatch");
    $finish;
  end

endmodule
